>>> rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

   // ring geometry
   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   // fixed field widths
   localparam int CAP_BITS = 5;
   localparam int OCC_BITS = 5;
   localparam int REQ_BITS = 2;
   localparam int ST_BITS  = 2;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_PUSH_REAR  = 2'd0,
      REQ_PUSH_FRONT = 2'd1,
      REQ_POP_FRONT  = 2'd2,
      REQ_POP_REAR   = 2'd3
   } req_kind_type;

   typedef enum logic [ST_BITS-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // result of one transaction, handed from the pointer logic to the result stage
   typedef struct packed {
      status_type          status;
      logic                pop_ok;
      logic                drained;
      logic                is_full;
      logic [CNT_BITS-1:0] occupancy;
   } result_type;

   // index after i in a ring of cap entries
   function automatic logic [IDX_BITS-1:0] next_idx(input logic [IDX_BITS-1:0] i,
                                                    input logic [CNT_BITS-1:0] cap);
      logic [CNT_BITS:0] inc;
      inc = {{(CNT_BITS + 1 - IDX_BITS){1'b0}}, i} + 1'b1;
      return (inc >= {1'b0, cap}) ? '0 : IDX_BITS'(inc);
   endfunction

   // index before i in a ring of cap entries
   function automatic logic [IDX_BITS-1:0] prev_idx(input logic [IDX_BITS-1:0] i,
                                                    input logic [CNT_BITS-1:0] cap);
      logic [CNT_BITS:0] wide_i;
      wide_i = {{(CNT_BITS + 1 - IDX_BITS){1'b0}}, i};
      if (i == '0 || wide_i >= {1'b0, cap})
         return IDX_BITS'(cap - 1'b1);
      else
         return i - 1'b1;
   endfunction

endpackage

>>> rtl/core/cdq_ram.sv
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read per cycle
module cdq_ram #(
   parameter int DEPTH_P = 16,
   parameter int WIDTH_P = 32,
   localparam int ABITS  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ABITS-1:0]   wr_addr,
   input  logic [WIDTH_P-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ABITS-1:0]   rd_addr,
   output logic [WIDTH_P-1:0] rd_data
);

   logic [WIDTH_P-1:0] mem [DEPTH_P];
   logic [WIDTH_P-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/cdq_ctrl.sv
`timescale 1ns / 1ps

// capacity register, head/tail/count pointers and memory access decode
module cdq_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [cdq_pkg::CAP_BITS-1:0]     csr_wr_data,
   input  logic                             accept,
   input  logic [cdq_pkg::REQ_BITS-1:0]     req_kind,
   output logic                             mem_wr_en,
   output logic [cdq_pkg::IDX_BITS-1:0]     mem_wr_addr,
   output logic                             mem_rd_en,
   output logic [cdq_pkg::IDX_BITS-1:0]     mem_rd_addr,
   output cdq_pkg::result_type              result
);

   logic [cdq_pkg::CAP_BITS-1:0] cap_ff;
   logic [cdq_pkg::IDX_BITS-1:0] head_ff, head_in;
   logic [cdq_pkg::IDX_BITS-1:0] tail_ff, tail_in;
   logic [cdq_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic [cdq_pkg::CNT_BITS-1:0] cap_eff;
   logic                         is_pop;

   // register value 0 acts as 1, above DEPTH acts as DEPTH
   always_comb begin
      if (cap_ff == '0)
         cap_eff = cdq_pkg::CNT_BITS'(1);
      else if (32'(cap_ff) > cdq_pkg::DEPTH)
         cap_eff = cdq_pkg::CNT_BITS'(cdq_pkg::DEPTH);
      else
         cap_eff = cdq_pkg::CNT_BITS'(cap_ff);
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      mem_wr_addr   = '0;
      mem_rd_addr   = head_ff;
      result.status = cdq_pkg::ST_DONE;
      result.pop_ok = 1'b0;
      is_pop        = 1'b0;

      case (cdq_pkg::req_kind_type'(req_kind))
         cdq_pkg::REQ_PUSH_REAR, cdq_pkg::REQ_PUSH_FRONT: begin
            if (count_ff >= cap_eff) begin
               result.status = cdq_pkg::ST_FULL;
            end else begin
               if (count_ff == '0) begin
                  head_in     = '0;
                  tail_in     = '0;
                  mem_wr_addr = '0;
               end else if (req_kind == cdq_pkg::REQ_PUSH_REAR) begin
                  tail_in     = cdq_pkg::next_idx(tail_ff, cap_eff);
                  mem_wr_addr = tail_in;
               end else begin
                  head_in     = cdq_pkg::prev_idx(head_ff, cap_eff);
                  mem_wr_addr = head_in;
               end
               count_in = count_ff + 1'b1;
            end
         end
         cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
            is_pop = 1'b1;
            if (count_ff == '0) begin
               result.status = cdq_pkg::ST_EMPTY;
            end else begin
               result.pop_ok = 1'b1;
               count_in      = count_ff - 1'b1;
               if (req_kind == cdq_pkg::REQ_POP_FRONT) begin
                  mem_rd_addr = head_ff;
                  head_in     = cdq_pkg::next_idx(head_ff, cap_eff);
               end else begin
                  mem_rd_addr = tail_ff;
                  tail_in     = cdq_pkg::prev_idx(tail_ff, cap_eff);
               end
               // last entry gone: both pointers back to the origin
               if (count_in == '0) begin
                  head_in = '0;
                  tail_in = '0;
               end
            end
         end
         default: begin
            result.status = cdq_pkg::ST_DONE;
         end
      endcase

      result.occupancy = count_in;
      result.drained   = (count_in == '0);
      result.is_full   = (count_in == cap_eff);
      mem_wr_en        = accept && !is_pop && (result.status == cdq_pkg::ST_DONE);
      mem_rd_en        = accept && result.pop_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= cdq_pkg::CAP_BITS'(16);
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (csr_wr_en) begin
         cap_ff   <= csr_wr_data;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/core/circular_deque.sv
`timescale 1ns / 1ps

// Channel | Dir | Ports (after the channel prefix)
// --------+-----+--------------------------------------------------------
// req     | in  | valid stall type data_word
// rsp     | out | valid stall status removed_word drained is_full occupancy
// csr     | in  | wr_en wr_data (capacity_in_use)
//
// One transaction per cycle while rsp_stall is low; the response passes
// through the registered read of the entry RAM, then the output register.
// Synchronous reset clears pointers, count, capacity (16) and all valid flags;
// the entry RAM is not cleared.
// A stall on rsp holds the output register; the pending stage then holds and
// req_stall rises until the output register frees up.
module circular_deque (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cdq_pkg::REQ_BITS-1:0]         req_type,
   input  logic signed [cdq_pkg::WORD_BITS-1:0] req_data_word,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cdq_pkg::ST_BITS-1:0]          rsp_status,
   output logic signed [cdq_pkg::WORD_BITS-1:0] rsp_removed_word,
   output logic                                 rsp_drained,
   output logic                                 rsp_is_full,
   output logic [cdq_pkg::OCC_BITS-1:0]         rsp_occupancy,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [cdq_pkg::CAP_BITS-1:0]         csr_wr_data
);

   logic                           accept;
   logic                           mem_wr_en;
   logic [cdq_pkg::IDX_BITS-1:0]   mem_wr_addr;
   logic                           mem_rd_en;
   logic [cdq_pkg::IDX_BITS-1:0]   mem_rd_addr;
   logic [cdq_pkg::WORD_BITS-1:0]  mem_rd_data;
   cdq_pkg::result_type            result;

   // pending stage: holds the result until the registered RAM read data arrives
   logic                           pend_valid_ff, pend_valid_in;
   cdq_pkg::result_type            pend_ff;

   // output register
   logic                           out_valid_ff, out_valid_in;
   logic [cdq_pkg::ST_BITS-1:0]    out_status_ff;
   logic [cdq_pkg::WORD_BITS-1:0]  out_word_ff;
   logic                           out_empty_ff;
   logic                           out_full_ff;
   logic [cdq_pkg::OCC_BITS-1:0]   out_occ_ff;

   logic                           out_free;
   logic                           pend_move;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign pend_move = pend_valid_ff && out_free;
   assign req_stall = pend_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   cdq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req_kind    (req_type),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .result      (result)
   );

   // entry store; a write and a read never hit the same entry in one cycle,
   // since one transaction is either a push or a pop
   cdq_ram #(
      .DEPTH_P (cdq_pkg::DEPTH),
      .WIDTH_P (cdq_pkg::WORD_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_data_word),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      pend_valid_in = accept ? 1'b1 : (pend_move ? 1'b0 : pend_valid_ff);
      out_valid_in  = pend_move ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= result;
      end
      if (pend_move) begin
         out_status_ff <= pend_ff.status;
         // read data only holds a word when the pop went through
         out_word_ff   <= pend_ff.pop_ok ? mem_rd_data : '0;
         out_empty_ff  <= pend_ff.drained;
         out_full_ff   <= pend_ff.is_full;
         out_occ_ff    <= cdq_pkg::OCC_BITS'(pend_ff.occupancy);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_removed_word = out_word_ff;
   assign rsp_drained      = out_empty_ff;
   assign rsp_is_full      = out_full_ff;
   assign rsp_occupancy    = out_occ_ff;

endmodule

>>> rtl/core/cdq_checker.sv
`timescale 1ns / 1ps

module cdq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [cdq_pkg::ST_BITS-1:0]          rsp_status,
   input logic signed [cdq_pkg::WORD_BITS-1:0] rsp_removed_word,
   input logic                                 rsp_drained,
   input logic                                 rsp_is_full,
   input logic [cdq_pkg::OCC_BITS-1:0]         rsp_occupancy
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_removed_word) && $stable(rsp_occupancy))
      else $error("stalled response changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drained == (rsp_occupancy == '0))
      else $error("empty flag disagrees with occupancy");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cdq_pkg::ST_DONE |-> rsp_removed_word == '0)
      else $error("refused transaction returned a word");

   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cdq_pkg::ST_FULL |-> rsp_is_full)
      else $error("full refusal while not full");

   a_empty_refusal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cdq_pkg::ST_EMPTY |-> rsp_drained)
      else $error("empty refusal while not empty");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_removed_word (rsp_removed_word),
   .rsp_drained      (rsp_drained),
   .rsp_is_full      (rsp_is_full),
   .rsp_occupancy    (rsp_occupancy)
);
